FILE: rtl/point_in_rotated_rectangle_macros.svh
// ----------------------------------------------------------------------------
// Point in rotated rectangle: assertion macros
// Short forms for the concurrent checks written in the RTL.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_ROTATED_RECTANGLE_MACROS_SVH
`define POINT_IN_ROTATED_RECTANGLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIRR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pirr check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pirr check failed");

`endif

FILE: rtl/pirr_pkg.sv
// ----------------------------------------------------------------------------
// Point in rotated rectangle: package
// Widths, angle constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pirr_pkg;

  // Sine table size: SINE_N + 1 entries cover a quarter turn inclusive.
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_N          = 1 << SINE_TABLE_BITS;

  // Angle units are sixteenths of a degree.
  localparam int HALF_TURN_DEG = 180;
  localparam int QUARTER_UNITS = HALF_TURN_DEG * 8;
  localparam int FULL_UNITS    = HALF_TURN_DEG * 32;

  localparam int ANGLE_W = 13;
  localparam int REST_W  = 11;
  localparam int NUM_W   = REST_W + SINE_TABLE_BITS;

  // Reciprocal of a quarter turn for the index division.
  localparam int RECIP_SHIFT = 36;
  localparam logic [31:0] RECIP_MUL = 32'((64'd1 << RECIP_SHIFT) / QUARTER_UNITS);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_word_t;
  typedef sine_word_t sine_rom_t [0:SINE_N];

  typedef logic [1:0] quad_t;

  // One entry of the table: Taylor series in Q30, rounded to Q15.
  function automatic sine_word_t sine_entry(int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x   = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
    x2  = (x * x) >> 30;
    mag = x;
    sum = $signed(x);
    for (int k = 1; k <= 12; k++) begin
      mag = ((mag * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q = $signed(($unsigned(sum) + 64'd16384) >> 15);
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[14:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t r;
    for (int i = 0; i <= SINE_N; i++) begin
      r[i] = sine_entry(i);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

FILE: rtl/pirr_if.sv
// ----------------------------------------------------------------------------
// Point in rotated rectangle: channel interfaces
// Query word in, one-bit result word out, both with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pirr_query_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] rect_x;
  logic signed [23:0] rect_y;
  logic [15:0]        rect_width;
  logic [15:0]        rect_height;
  logic [12:0]        rect_angle;

  modport source (output valid, point_x, point_y, rect_x, rect_y, rect_width,
                  rect_height, rect_angle, input ready);
  modport sink (input valid, point_x, point_y, rect_x, rect_y, rect_width,
                rect_height, rect_angle, output ready);
endinterface

interface pirr_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

FILE: rtl/pirr_sincos.sv
// ----------------------------------------------------------------------------
// Point in rotated rectangle: sine and cosine pipeline
// Five stages from angle to signed Q1.15 sine and cosine via the quarter table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pirr_sincos
  import pirr_pkg::*;
(
  input  logic                  clk,
  input  logic                  adv,
  input  logic [ANGLE_W-1:0]    angle,
  output logic signed [15:0]    sin_val,
  output logic signed [15:0]    cos_val
);

  logic [ANGLE_W-1:0]          ang_wrap;
  quad_t                       quad_c;
  logic [REST_W-1:0]           rest_c;

  quad_t                       quad1, quad2, quad3, quad4;
  logic [REST_W-1:0]           rest1;
  logic [NUM_W-1:0]            num2;
  logic [SINE_TABLE_BITS-1:0]  q0;
  logic [NUM_W+31:0]           prod;
  logic [NUM_W-1:0]            rem3;
  logic [SINE_TABLE_BITS-1:0]  idx3;
  logic [SINE_TABLE_BITS:0]    idx_ext;
  logic [SINE_TABLE_BITS:0]    cidx;
  sine_word_t                  t4, tc4;
  logic signed [15:0]          t_s, tc_s;

  // Stage 1: wrap the angle to one turn and split off the quadrant.
  always_comb begin
    if (angle >= ANGLE_W'(FULL_UNITS)) begin
      ang_wrap = angle - ANGLE_W'(FULL_UNITS);
    end else begin
      ang_wrap = angle;
    end
    if (ang_wrap >= ANGLE_W'(3 * QUARTER_UNITS)) begin
      quad_c = 2'd3;
      rest_c = REST_W'(ang_wrap - ANGLE_W'(3 * QUARTER_UNITS));
    end else if (ang_wrap >= ANGLE_W'(2 * QUARTER_UNITS)) begin
      quad_c = 2'd2;
      rest_c = REST_W'(ang_wrap - ANGLE_W'(2 * QUARTER_UNITS));
    end else if (ang_wrap >= ANGLE_W'(QUARTER_UNITS)) begin
      quad_c = 2'd1;
      rest_c = REST_W'(ang_wrap - ANGLE_W'(QUARTER_UNITS));
    end else begin
      quad_c = 2'd0;
      rest_c = REST_W'(ang_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quad1 <= quad_c;
      rest1 <= rest_c;
    end
  end

  // Stage 2: estimate of rest * N / quarter turn by reciprocal multiply.
  assign prod = {rest1, {SINE_TABLE_BITS{1'b0}}} * RECIP_MUL;

  always_ff @(posedge clk) begin
    if (adv) begin
      quad2 <= quad1;
      num2  <= {rest1, {SINE_TABLE_BITS{1'b0}}};
      q0    <= SINE_TABLE_BITS'(prod >> RECIP_SHIFT);
    end
  end

  // Stage 3: the estimate is low by at most one; correct with the remainder.
  assign rem3 = num2 - NUM_W'(q0 * NUM_W'(QUARTER_UNITS));
  assign idx3 = (rem3 >= NUM_W'(QUARTER_UNITS)) ? q0 + 1'b1 : q0;

  always_ff @(posedge clk) begin
    if (adv) begin
      quad3   <= quad2;
      idx_ext <= {1'b0, idx3};
    end
  end

  // Stage 4: two registered table reads, at the index and its complement.
  assign cidx = (SINE_TABLE_BITS + 1)'(SINE_N) - idx_ext;

  always_ff @(posedge clk) begin
    if (adv) begin
      quad4 <= quad3;
      t4    <= SINE_ROM[idx_ext];
      tc4   <= SINE_ROM[cidx];
    end
  end

  // Stage 5: place the table values by quadrant.
  assign t_s  = $signed({1'b0, t4});
  assign tc_s = $signed({1'b0, tc4});

  always_ff @(posedge clk) begin
    if (adv) begin
      case (quad4)
        2'd0: begin
          sin_val <= t_s;
          cos_val <= tc_s;
        end
        2'd1: begin
          sin_val <= tc_s;
          cos_val <= -t_s;
        end
        2'd2: begin
          sin_val <= -t_s;
          cos_val <= -tc_s;
        end
        default: begin
          sin_val <= -tc_s;
          cos_val <= t_s;
        end
      endcase
    end
  end

endmodule

FILE: rtl/point_in_rotated_rectangle.sv
// Pipeline: nine register stages lie between the edge that accepts a query
// word and the output register that holds its result word.
// Throughput: one word per cycle; the nine stages advance together and hold
// while the output register waits for ready.
// Reset: rst (synchronous, active high) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// Point in rotated rectangle
// Tests whether a query point lies inside a rectangle rotated about its anchor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_rotated_rectangle_macros.svh"

module point_in_rotated_rectangle
  import pirr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  pirr_query_if.sink        query,
  pirr_result_if.source     result
);

  localparam int STAGES = 9;
  localparam int DLY    = 5;

  logic                     adv;
  logic [STAGES:1]          vld;

  logic signed [15:0]       sin_val, cos_val;

  logic signed [24:0]       dx_d [1:DLY];
  logic signed [24:0]       dy_d [1:DLY];
  logic [15:0]              w_d  [1:DLY+2];
  logic [15:0]              h_d  [1:DLY+2];

  logic signed [41:0]       c_dy6, s_dx6, s_dy6, c_dx6;
  logic [31:0]              cc6, ss6;
  logic signed [42:0]       a7, b7, a8, b8;
  logic [31:0]              k7;
  logic [47:0]              wk8, hk8;
  logic                     wz8, hz8;
  logic signed [52:0]       e2_sum, e3_sum;
  logic                     hit;

  // The whole pipe moves when the output register is free or being read.
  assign adv          = !vld[STAGES] || result.ready;
  assign query.ready  = adv;
  assign result.valid = vld[STAGES];
  assign result.inside_res = hit;

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-1:1], query.valid};
    end
  end

  pirr_sincos u_sincos (
    .clk     (clk),
    .adv     (adv),
    .angle   (query.rect_angle),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  // Offsets and sizes wait in delay lines while the angle is looked up.
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_d[1] <= 25'(query.point_x) - 25'(query.rect_x);
      dy_d[1] <= 25'(query.point_y) - 25'(query.rect_y);
      w_d[1]  <= query.rect_width;
      h_d[1]  <= query.rect_height;
      for (int i = 2; i <= DLY; i++) begin
        dx_d[i] <= dx_d[i-1];
        dy_d[i] <= dy_d[i-1];
      end
      for (int i = 2; i <= DLY + 2; i++) begin
        w_d[i] <= w_d[i-1];
        h_d[i] <= h_d[i-1];
      end
    end
  end

  // Stage 6: all products of the direction with the offset, and the squares of sine and cosine.
  always_ff @(posedge clk) begin
    if (adv) begin
      c_dy6 <= 42'(cos_val * dy_d[DLY]);
      s_dx6 <= 42'(sin_val * dx_d[DLY]);
      s_dy6 <= 42'(sin_val * dy_d[DLY]);
      c_dx6 <= 42'(cos_val * dx_d[DLY]);
      cc6   <= 32'($unsigned(32'(cos_val * cos_val)));
      ss6   <= 32'($unsigned(32'(sin_val * sin_val)));
    end
  end

  // Stage 7: cross products along both axes and the squared length.
  always_ff @(posedge clk) begin
    if (adv) begin
      a7 <= 43'(c_dy6) - 43'(s_dx6);
      b7 <= -43'(s_dy6) - 43'(c_dx6);
      k7 <= cc6 + ss6;
    end
  end

  // Stage 8: scale the squared length by width and height.
  always_ff @(posedge clk) begin
    if (adv) begin
      a8  <= a7;
      b8  <= b7;
      wk8 <= w_d[DLY+2] * k7;
      hk8 <= h_d[DLY+2] * k7;
      wz8 <= (w_d[DLY+2] == '0);
      hz8 <= (h_d[DLY+2] == '0);
    end
  end

  // Stage 9: signs of the far edges and the final decision.
  assign e2_sum = (53'(b8) <<< 8) + $signed({4'd0, wk8, 1'b0});
  assign e3_sum = $signed({4'd0, hk8, 1'b0}) - (53'(a8) <<< 8);

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= (wz8 || !a8[42]) && (hz8 || !e2_sum[52]) &&
             (wz8 || !e3_sum[52]) && (hz8 || (b8 <= 0));
    end
  end

  // A degenerate rectangle of zero width and height contains every point.
  `PIRR_ASSERT_NEXT(a_degenerate_inside, adv && vld[STAGES-1] && wz8 && hz8, hit)
  // A stall freezes every stage valid bit.
  `PIRR_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld))
  // Ready follows the output register's valid bit and the result ready, and nothing else.
  `PIRR_ASSERT_SAME(a_ready_rule, 1'b1, query.ready == (!result.valid || result.ready))

endmodule

FILE: tb/sv/pirr_tb_if.sv
// ----------------------------------------------------------------------------
// Point in rotated rectangle: testbench package
// The plain data type that describes one query word in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The channel interfaces themselves come from the RTL; this file holds the
// plain data type that the testbench uses to describe one query word.
package pirr_tb_pkg;

  typedef struct {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] rect_x;
    logic signed [23:0] rect_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
    logic [12:0]        rect_angle;
  } query_word_t;

endpackage

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Point in rotated rectangle testbench
// Drives query words with random gaps and stalls, predicts the inside flag of
// each one from its own sine table and exact cross products, and checks every
// result word in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import pirr_pkg::*;
  import pirr_tb_pkg::*;
();

  // Scoreboard: works out the inside flag for each accepted query word and
  // compares result words against the oldest outstanding flag.
  class hit_scoreboard;
    logic [14:0] sine_q15 [0:SINE_N];
    bit          pending_hits [$];
    int          mismatches;
    int          checked;
    int          hits;

    function new();
      for (int i = 0; i <= SINE_N; i++) begin
        sine_q15[i] = taylor_sine(i);
      end
      mismatches = 0;
      checked = 0;
      hits = 0;
    endfunction

    // Quarter-wave entry: Taylor series in Q30, rounded half up to Q15.
    function logic [14:0] taylor_sine(int unsigned i);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          acc;
      longint          q;
      x   = (64'd1686629713 * 64'(i)) >> SINE_TABLE_BITS;
      x2  = (x * x) >> 30;
      mag = x;
      acc = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        mag = ((mag * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - longint'(mag);
        end else begin
          acc = acc + longint'(mag);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      q = longint'((unsigned'(acc) + 64'd16384) >> 15);
      if (q > 32767) begin
        q = 32767;
      end
      return q[14:0];
    endfunction

    function bit point_inside(query_word_t w);
      int unsigned ang;
      int unsigned quad;
      int unsigned idx;
      longint      t;
      longint      tc;
      longint      sn;
      longint      cs;
      longint      dx;
      longint      dy;
      longint      ca;
      longint      cb;
      longint      len2;
      longint      wd;
      longint      ht;
      bit          e1;
      bit          e2;
      bit          e3;
      bit          e4;
      ang  = int'(w.rect_angle) % FULL_UNITS;
      quad = ang / QUARTER_UNITS;
      idx  = ((ang % QUARTER_UNITS) << SINE_TABLE_BITS) / QUARTER_UNITS;
      t    = sine_q15[idx];
      tc   = sine_q15[SINE_N - idx];
      case (quad)
        0: begin sn = t;   cs = tc;  end
        1: begin sn = tc;  cs = -t;  end
        2: begin sn = -t;  cs = -tc; end
        default: begin sn = -tc; cs = t; end
      endcase
      dx   = longint'(w.point_x) - longint'(w.rect_x);
      dy   = longint'(w.point_y) - longint'(w.rect_y);
      ca   = cs * dy - sn * dx;
      cb   = -sn * dy - cs * dx;
      len2 = cs * cs + sn * sn;
      wd   = w.rect_width;
      ht   = w.rect_height;
      e1 = (wd == 0) || (ca >= 0);
      e2 = (ht == 0) || (cb * 256 + 2 * wd * len2 >= 0);
      e3 = (wd == 0) || (-ca * 256 + 2 * ht * len2 >= 0);
      e4 = (ht == 0) || (cb <= 0);
      return e1 && e2 && e3 && e4;
    endfunction

    function void note_query(query_word_t w);
      bit r;
      r = point_inside(w);
      hits += r;
      pending_hits.push_back(r);
    endfunction

    function void check_result(logic got);
      bit want;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %b", $time, got);
        mismatches++;
        return;
      end
      want = pending_hits.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: inside_res mismatch, expected %b, actual %b", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 1330;
  localparam int LONG_STALL_AT = 450;
  localparam int LONG_STALL_CYCLES = 60;

  logic clk;
  logic rst;

  pirr_query_if  query ();
  pirr_result_if result ();

  point_in_rotated_rectangle dut (
    .clk   (clk),
    .rst   (rst),
    .query (query.sink),
    .result(result.source)
  );

  hit_scoreboard board;
  query_word_t   directed_words [$];
  int            quiet_cycles;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic query_word_t query_item();
    query_word_t w;
    w.point_x     = query.point_x;
    w.point_y     = query.point_y;
    w.rect_x      = query.rect_x;
    w.rect_y      = query.rect_y;
    w.rect_width  = query.rect_width;
    w.rect_height = query.rect_height;
    w.rect_angle  = query.rect_angle;
    return w;
  endfunction

  // Note accepted query words and check result words at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (query.valid && query.ready) begin
        board.note_query(query_item());
      end
      if (result.valid && result.ready) begin
        board.check_result(result.inside_res);
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (query.valid && query.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("point_in_rotated_rectangle regression: fail");
        $finish;
      end
    end
  end

  function automatic query_word_t make_word(int px, int py, int ax, int ay,
                                            int wd, int ht, int ang);
    query_word_t w;
    w.point_x     = 24'(px);
    w.point_y     = 24'(py);
    w.rect_x      = 24'(ax);
    w.rect_y      = 24'(ay);
    w.rect_width  = 16'(wd);
    w.rect_height = 16'(ht);
    w.rect_angle  = 13'(ang);
    return w;
  endfunction

  // Random word: mostly points near a modest rectangle so both answers occur,
  // with some words spread over the whole field ranges.
  function automatic query_word_t random_word();
    query_word_t w;
    int          ax;
    int          ay;
    int          wd;
    int          ht;
    int          span;
    if ($urandom_range(0, 4) == 0) begin
      w.point_x     = 24'($urandom);
      w.point_y     = 24'($urandom);
      w.rect_x      = 24'($urandom);
      w.rect_y      = 24'($urandom);
      w.rect_width  = 16'($urandom);
      w.rect_height = 16'($urandom);
      w.rect_angle  = 13'($urandom);
      return w;
    end
    ax = $urandom_range(0, 200000) - 100000;
    ay = $urandom_range(0, 200000) - 100000;
    wd = $urandom_range(0, 300);
    ht = $urandom_range(0, 300);
    span = (wd > ht ? wd : ht) * 256 + 256;
    w.rect_x      = 24'(ax);
    w.rect_y      = 24'(ay);
    w.rect_width  = 16'(wd);
    w.rect_height = 16'(ht);
    w.point_x     = 24'(ax + $urandom_range(0, 2 * span) - span);
    w.point_y     = 24'(ay + $urandom_range(0, 2 * span) - span);
    w.rect_angle  = 13'($urandom_range(0, 8191));
    return w;
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic send_word(query_word_t w);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query.valid       <= 1'b1;
    query.point_x     <= w.point_x;
    query.point_y     <= w.point_y;
    query.rect_x      <= w.rect_x;
    query.rect_y      <= w.rect_y;
    query.rect_width  <= w.rect_width;
    query.rect_height <= w.rect_height;
    query.rect_angle  <= w.rect_angle;
    do begin
      @(posedge clk);
    end while (!query.ready);
    @(negedge clk);
  endtask

  // Receiver: random stalls per word, plus one long hold-off partway through.
  initial begin
    int stall;
    int taken;
    taken = 0;
    result.ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (taken == LONG_STALL_AT) begin
        result.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(negedge clk);
      end
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) begin
        stall = 0;
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!result.valid);
      taken++;
      @(negedge clk);
    end
  end

  // Sender and end of run.
  initial begin
    board = new();
    query.valid       = 1'b0;
    query.point_x     = '0;
    query.point_y     = '0;
    query.rect_x      = '0;
    query.rect_y      = '0;
    query.rect_width  = '0;
    query.rect_height = '0;
    query.rect_angle  = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: field extremes, each quadrant, zero sizes, wrapped angles.
    directed_words.push_back(make_word(512, 256, 0, 0, 4, 2, 0));
    directed_words.push_back(make_word(-256, 256, 0, 0, 4, 2, 0));
    directed_words.push_back(make_word(1024, 512, 0, 0, 4, 2, 0));
    directed_words.push_back(make_word(-256, 512, 0, 0, 4, 2, 1440));
    directed_words.push_back(make_word(-512, -256, 0, 0, 4, 2, 2880));
    directed_words.push_back(make_word(256, -512, 0, 0, 4, 2, 4320));
    directed_words.push_back(make_word(300, 300, 0, 0, 4, 4, 720));
    directed_words.push_back(make_word(0, 0, 0, 0, 0, 0, 100));
    directed_words.push_back(make_word(-8388608, 8388607, 0, 0, 0, 0, 5759));
    directed_words.push_back(make_word(512, 0, 0, 0, 4, 0, 0));
    directed_words.push_back(make_word(512, 5, 0, 0, 4, 0, 0));
    directed_words.push_back(make_word(0, 512, 0, 0, 0, 4, 0));
    directed_words.push_back(make_word(8388607, 8388607, -8388608, -8388608,
                                       65535, 65535, 5759));
    directed_words.push_back(make_word(-8388608, -8388608, 8388607, 8388607,
                                       65535, 65535, 2880));
    directed_words.push_back(make_word(100, 100, 0, 0, 65535, 65535, 0));
    directed_words.push_back(make_word(512, 256, 0, 0, 4, 2, 5760));
    directed_words.push_back(make_word(-256, 512, 0, 0, 4, 2, 7200));
    directed_words.push_back(make_word(0, 0, 0, 0, 4, 2, 8191));
    directed_words.push_back(make_word(1024, 0, 0, 0, 4, 2, 0));
    directed_words.push_back(make_word(0, 0, 256, 256, 1, 1, 1439));
    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end

    // Random words; the receiver holds off for a long stretch partway through.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_word());
    end
    query.valid <= 1'b0;

    while (board.pending_hits.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Checked %0d result words, %0d of them inside, %0d mismatches.",
             board.checked, board.hits, board.mismatches);
    $display("Covered all quadrants, zero sizes, wrapped angles and a long stall.");
    if (board.mismatches == 0) begin
      $display("point_in_rotated_rectangle regression: pass");
    end else begin
      $display("point_in_rotated_rectangle regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/pirr_pkg.sv
rtl/pirr_if.sv
rtl/pirr_sincos.sv
rtl/point_in_rotated_rectangle.sv
tb/sv/pirr_tb_if.sv
tb/sv/tb.sv
